@@ sv/clgt_pkg.sv @@
// Shared widths, codes and parameter defaults for the cached lock grant table.
`default_nettype none

package clgt_pkg;

   localparam int ACTION_W    = 2;
   localparam int LOCK_ID_W   = 6;
   localparam int CLIENT_W    = 4;
   localparam int STATUS_W    = 2;
   localparam int HELD_CNT_W  = 7;

   localparam int DEF_NUM_LOCKS   = 64;
   localparam int DEF_QUEUE_DEPTH = 8;

   localparam logic [ACTION_W-1:0] ACT_ACQUIRE = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_RELEASE = 2'd1;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_RETRY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_RPC   = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd3;

   localparam logic MSG_REVOKE = 1'b0;
   localparam logic MSG_RETRY  = 1'b1;

   localparam logic [HELD_CNT_W-1:0] HELD_MAX = 7'd127;

endpackage

`default_nettype wire

@@ sv/clgt_step_unit.sv @@
// Shared modular adder that forms queue positions from a head and an offset.
`default_nettype none

module clgt_step_unit #(
   parameter  int QUEUE_DEPTH = 8,
   localparam int POS_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1)
) (
   input  logic [POS_W-1:0] base_pos,
   input  logic [CNT_W-1:0] offset,
   output logic [POS_W-1:0] pos
);

   logic [CNT_W:0] sum;
   logic [CNT_W:0] wrapped;

   always_comb begin
      sum     = (CNT_W+1)'(base_pos) + (CNT_W+1)'(offset);
      wrapped = sum - (CNT_W+1)'(QUEUE_DEPTH);
      if (sum >= (CNT_W+1)'(QUEUE_DEPTH)) begin
         pos = POS_W'(wrapped);
      end else begin
         pos = POS_W'(sum);
      end
   end

endmodule

`default_nettype wire

@@ sv/clgt_wait_mem.sv @@
// Waiter store: one slot per lock and queue position, registered read.
`default_nettype none

module clgt_wait_mem #(
   parameter  int DEPTH = 512,
   localparam int AW    = $clog2(DEPTH)
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [AW-1:0]                 wr_addr,
   input  logic [clgt_pkg::CLIENT_W-1:0] wr_data,
   input  logic [AW-1:0]                 rd_addr,
   output logic [clgt_pkg::CLIENT_W-1:0] rd_data
);

   import clgt_pkg::*;

   logic [CLIENT_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

@@ sv/clgt_lock_mem.sv @@
// Lock table: held flag, owner, queue head and queue count per lock.
`default_nettype none

module clgt_lock_mem #(
   parameter  int NUM_LOCKS   = 64,
   parameter  int QUEUE_DEPTH = 8,
   localparam int LIDX_W      = $clog2(NUM_LOCKS),
   localparam int POS_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1)
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [LIDX_W-1:0]             wr_addr,
   input  logic                          wr_held,
   input  logic [clgt_pkg::CLIENT_W-1:0] wr_owner,
   input  logic [POS_W-1:0]              wr_head,
   input  logic [CNT_W-1:0]              wr_count,
   input  logic [LIDX_W-1:0]             rd_addr,
   output logic                          rd_held,
   output logic [clgt_pkg::CLIENT_W-1:0] rd_owner,
   output logic [POS_W-1:0]              rd_head,
   output logic [CNT_W-1:0]              rd_count
);

   import clgt_pkg::*;

   logic                held_mem  [NUM_LOCKS];
   logic [CLIENT_W-1:0] owner_mem [NUM_LOCKS];
   logic [POS_W-1:0]    head_mem  [NUM_LOCKS];
   logic [CNT_W-1:0]    count_mem [NUM_LOCKS];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         held_mem[wr_addr]  <= wr_held;
         owner_mem[wr_addr] <= wr_owner;
         head_mem[wr_addr]  <= wr_head;
         count_mem[wr_addr] <= wr_count;
      end
      rd_held  <= held_mem[rd_addr];
      rd_owner <= owner_mem[rd_addr];
      rd_head  <= head_mem[rd_addr];
      rd_count <= count_mem[rd_addr];
   end

endmodule

`default_nettype wire

@@ sv/cached_lock_grant_table.sv @@
// Top level of the cached lock grant table and its request sequencer.
//
// After reset the block clears its lock table, one lock a cycle, with busy
// high. A request is taken when start is high and busy is low, and its
// response appears on the rsp_ ports for exactly one cycle, marked by
// rsp_strobe; the receiver cannot stall it, so it must take every
// transaction as it comes. A stat query or an out-of-range lock answers in
// the cycle after acceptance and leaves busy low. A grant, a free or a full
// queue answers from the look state, once the lock entry is read. A queued
// acquire or a hand-over on release goes on through the fetch and use states,
// as the waiter store is read and written at one shared address and queue
// positions are formed one after another by a single shared modular adder.
`default_nettype none

module cached_lock_grant_table #(
   parameter int NUM_LOCKS   = clgt_pkg::DEF_NUM_LOCKS,
   parameter int QUEUE_DEPTH = clgt_pkg::DEF_QUEUE_DEPTH
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [clgt_pkg::ACTION_W-1:0]   req_action,
   input  logic [clgt_pkg::LOCK_ID_W-1:0]  req_lock_id,
   input  logic [clgt_pkg::CLIENT_W-1:0]   req_client_id,
   input  logic                            req_target_reachable,
   output logic                            rsp_strobe,
   output logic [clgt_pkg::STATUS_W-1:0]   rsp_status,
   output logic                            rsp_msg_valid,
   output logic                            rsp_msg_kind,
   output logic [clgt_pkg::CLIENT_W-1:0]   rsp_msg_client,
   output logic [clgt_pkg::LOCK_ID_W-1:0]  rsp_msg_lock,
   output logic [clgt_pkg::HELD_CNT_W-1:0] rsp_held_count
);

   import clgt_pkg::*;

   localparam int LIDX_W  = $clog2(NUM_LOCKS);
   localparam int POS_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
   localparam int WDEPTH  = NUM_LOCKS * QUEUE_DEPTH;
   localparam int WADDR_W = $clog2(WDEPTH);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOK,
      ST_FETCH,
      ST_USE
   } state_type;

   state_type              state_ff, state_in;
   logic [LIDX_W-1:0]      clr_ff, clr_in;
   logic [ACTION_W-1:0]    act_ff, act_in;
   logic [LOCK_ID_W-1:0]   lock_id_ff, lock_id_in;
   logic [CLIENT_W-1:0]    client_ff, client_in;
   logic                   reach_ff, reach_in;
   logic [WADDR_W-1:0]     base_ff, base_in;
   logic [POS_W-1:0]       pos_ff, pos_in;
   logic                   ent_held_ff, ent_held_in;
   logic [CLIENT_W-1:0]    ent_owner_ff, ent_owner_in;
   logic [POS_W-1:0]       ent_head_ff, ent_head_in;
   logic [CNT_W-1:0]       ent_count_ff, ent_count_in;
   logic [HELD_CNT_W-1:0]  total_ff, total_in;
   logic                   rsp_strobe_ff, rsp_strobe_in;
   logic [STATUS_W-1:0]    rsp_status_ff, rsp_status_in;
   logic                   rsp_msg_valid_ff, rsp_msg_valid_in;
   logic                   rsp_msg_kind_ff, rsp_msg_kind_in;
   logic [CLIENT_W-1:0]    rsp_msg_client_ff, rsp_msg_client_in;
   logic [LOCK_ID_W-1:0]   rsp_msg_lock_ff, rsp_msg_lock_in;
   logic [HELD_CNT_W-1:0]  rsp_held_count_ff, rsp_held_count_in;

   logic                   lk_wr_en;
   logic [LIDX_W-1:0]      lk_wr_addr;
   logic                   lk_wr_held;
   logic [CLIENT_W-1:0]    lk_wr_owner;
   logic [POS_W-1:0]       lk_wr_head;
   logic [CNT_W-1:0]       lk_wr_count;
   logic [LIDX_W-1:0]      lk_rd_addr;
   logic                   lk_rd_held;
   logic [CLIENT_W-1:0]    lk_rd_owner;
   logic [POS_W-1:0]       lk_rd_head;
   logic [CNT_W-1:0]       lk_rd_count;

   logic                   wt_wr_en;
   logic [WADDR_W-1:0]     wt_addr;
   logic [CLIENT_W-1:0]    wt_rd_data;

   logic [POS_W-1:0]       unit_a;
   logic [CNT_W-1:0]       unit_b;
   logic [POS_W-1:0]       unit_sum;

   logic                   is_acq;
   logic                   req_ok;
   logic [CNT_W-1:0]       rd_count_m1;
   logic [CLIENT_W-1:0]    target;

   clgt_lock_mem #(
      .NUM_LOCKS   (NUM_LOCKS),
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_lock_mem (
      .clock    (clock),
      .wr_en    (lk_wr_en),
      .wr_addr  (lk_wr_addr),
      .wr_held  (lk_wr_held),
      .wr_owner (lk_wr_owner),
      .wr_head  (lk_wr_head),
      .wr_count (lk_wr_count),
      .rd_addr  (lk_rd_addr),
      .rd_held  (lk_rd_held),
      .rd_owner (lk_rd_owner),
      .rd_head  (lk_rd_head),
      .rd_count (lk_rd_count)
   );

   clgt_wait_mem #(
      .DEPTH (WDEPTH)
   ) u_wait_mem (
      .clock   (clock),
      .wr_en   (wt_wr_en),
      .wr_addr (wt_addr),
      .wr_data (client_ff),
      .rd_addr (wt_addr),
      .rd_data (wt_rd_data)
   );

   clgt_step_unit #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_step_unit (
      .base_pos (unit_a),
      .offset   (unit_b),
      .pos      (unit_sum)
   );

   assign is_acq      = (act_ff == ACT_ACQUIRE);
   assign req_ok      = ((req_action == ACT_ACQUIRE) || (req_action == ACT_RELEASE))
                        && (32'(req_lock_id) < NUM_LOCKS);
   assign rd_count_m1 = (lk_rd_count == '0) ? '0 : lk_rd_count - CNT_W'(1);
   assign target      = (ent_count_ff == '0) ? ent_owner_ff : wt_rd_data;
   assign wt_addr     = base_ff + WADDR_W'(pos_ff);
   assign lk_rd_addr  = (state_ff == ST_IDLE) ? LIDX_W'(req_lock_id) : LIDX_W'(lock_id_ff);

   always_comb begin
      state_in          = state_ff;
      clr_in            = clr_ff;
      act_in            = act_ff;
      lock_id_in        = lock_id_ff;
      client_in         = client_ff;
      reach_in          = reach_ff;
      base_in           = base_ff;
      pos_in            = pos_ff;
      ent_held_in       = ent_held_ff;
      ent_owner_in      = ent_owner_ff;
      ent_head_in       = ent_head_ff;
      ent_count_in      = ent_count_ff;
      total_in          = total_ff;
      rsp_strobe_in     = 1'b0;
      rsp_status_in     = rsp_status_ff;
      rsp_msg_valid_in  = rsp_msg_valid_ff;
      rsp_msg_kind_in   = rsp_msg_kind_ff;
      rsp_msg_client_in = rsp_msg_client_ff;
      rsp_msg_lock_in   = rsp_msg_lock_ff;
      rsp_held_count_in = rsp_held_count_ff;
      lk_wr_en          = 1'b0;
      lk_wr_addr        = LIDX_W'(lock_id_ff);
      lk_wr_held        = 1'b0;
      lk_wr_owner       = '0;
      lk_wr_head        = '0;
      lk_wr_count       = '0;
      wt_wr_en          = 1'b0;
      unit_a            = ent_head_ff;
      unit_b            = is_acq ? ent_count_ff : CNT_W'(1);

      case (state_ff)
         ST_CLEAR: begin
            lk_wr_en   = 1'b1;
            lk_wr_addr = clr_ff;
            clr_in     = clr_ff + LIDX_W'(1);
            if (clr_ff == LIDX_W'(NUM_LOCKS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               act_in     = req_action;
               lock_id_in = req_lock_id;
               client_in  = req_client_id;
               reach_in   = req_target_reachable;
               base_in    = WADDR_W'(32'(LIDX_W'(req_lock_id)) * QUEUE_DEPTH);
               if (req_ok) begin
                  state_in = ST_LOOK;
               end else begin
                  rsp_strobe_in     = 1'b1;
                  rsp_status_in     = STATUS_OK;
                  rsp_msg_valid_in  = 1'b0;
                  rsp_msg_kind_in   = 1'b0;
                  rsp_msg_client_in = '0;
                  rsp_msg_lock_in   = '0;
               end
            end
         end
         ST_LOOK: begin
            ent_held_in  = lk_rd_held;
            ent_owner_in = lk_rd_owner;
            ent_head_in  = lk_rd_head;
            ent_count_in = lk_rd_count;
            unit_a       = lk_rd_head;
            unit_b       = is_acq ? rd_count_m1 : '0;
            pos_in       = unit_sum;
            rsp_msg_valid_in  = 1'b0;
            rsp_msg_kind_in   = 1'b0;
            rsp_msg_client_in = '0;
            rsp_msg_lock_in   = '0;
            rsp_status_in     = STATUS_OK;
            if (is_acq) begin
               if (!lk_rd_held) begin
                  lk_wr_en      = 1'b1;
                  lk_wr_held    = 1'b1;
                  lk_wr_owner   = client_ff;
                  lk_wr_head    = lk_rd_head;
                  lk_wr_count   = lk_rd_count;
                  total_in      = (total_ff != HELD_MAX) ? total_ff + HELD_CNT_W'(1) : total_ff;
                  rsp_strobe_in = 1'b1;
                  state_in      = ST_IDLE;
               end else if (lk_rd_count >= CNT_W'(QUEUE_DEPTH)) begin
                  rsp_status_in = STATUS_FULL;
                  rsp_strobe_in = 1'b1;
                  state_in      = ST_IDLE;
               end else begin
                  state_in = ST_FETCH;
               end
            end else if (lk_rd_count != '0) begin
               state_in = ST_FETCH;
            end else begin
               lk_wr_en    = 1'b1;
               lk_wr_held  = 1'b0;
               lk_wr_owner = '0;
               lk_wr_head  = lk_rd_head;
               lk_wr_count = lk_rd_count;
               if (lk_rd_held && (total_ff != '0)) begin
                  total_in = total_ff - HELD_CNT_W'(1);
               end
               rsp_strobe_in = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         ST_FETCH: begin
            pos_in   = unit_sum;
            state_in = ST_USE;
         end
         ST_USE: begin
            lk_wr_en      = 1'b1;
            rsp_strobe_in = 1'b1;
            state_in      = ST_IDLE;
            if (is_acq) begin
               wt_wr_en          = 1'b1;
               lk_wr_held        = ent_held_ff;
               lk_wr_owner       = ent_owner_ff;
               lk_wr_head        = ent_head_ff;
               lk_wr_count       = ent_count_ff + CNT_W'(1);
               rsp_status_in     = reach_ff ? STATUS_RETRY : STATUS_RPC;
               rsp_msg_valid_in  = reach_ff;
               rsp_msg_kind_in   = MSG_REVOKE;
               rsp_msg_client_in = reach_ff ? target : '0;
               rsp_msg_lock_in   = reach_ff ? lock_id_ff : '0;
            end else begin
               lk_wr_held        = 1'b1;
               lk_wr_owner       = wt_rd_data;
               lk_wr_head        = pos_ff;
               lk_wr_count       = ent_count_ff - CNT_W'(1);
               rsp_status_in     = reach_ff ? STATUS_OK : STATUS_RPC;
               rsp_msg_valid_in  = reach_ff;
               rsp_msg_kind_in   = reach_ff ? MSG_RETRY : 1'b0;
               rsp_msg_client_in = reach_ff ? wt_rd_data : '0;
               rsp_msg_lock_in   = reach_ff ? lock_id_ff : '0;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (rsp_strobe_in) begin
         rsp_held_count_in = total_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ff        <= '0;
         total_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         total_ff      <= total_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      act_ff            <= act_in;
      lock_id_ff        <= lock_id_in;
      client_ff         <= client_in;
      reach_ff          <= reach_in;
      base_ff           <= base_in;
      pos_ff            <= pos_in;
      ent_held_ff       <= ent_held_in;
      ent_owner_ff      <= ent_owner_in;
      ent_head_ff       <= ent_head_in;
      ent_count_ff      <= ent_count_in;
      rsp_status_ff     <= rsp_status_in;
      rsp_msg_valid_ff  <= rsp_msg_valid_in;
      rsp_msg_kind_ff   <= rsp_msg_kind_in;
      rsp_msg_client_ff <= rsp_msg_client_in;
      rsp_msg_lock_ff   <= rsp_msg_lock_in;
      rsp_held_count_ff <= rsp_held_count_in;
   end

   assign busy           = (state_ff != ST_IDLE);
   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_msg_valid  = rsp_msg_valid_ff;
   assign rsp_msg_kind   = rsp_msg_kind_ff;
   assign rsp_msg_client = rsp_msg_client_ff;
   assign rsp_msg_lock   = rsp_msg_lock_ff;
   assign rsp_held_count = rsp_held_count_ff;

   // No transaction may complete while the lock table is being cleared.
   a_no_rsp_in_clear: assert property (@(posedge clock)
      (state_ff == ST_CLEAR) |-> !rsp_strobe)
      else $error("response during table clear");

   // An accepted request either answers at once or keeps the block busy.
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (rsp_strobe || busy))
      else $error("accepted request neither answered nor in progress");

   // A message is only sent with an ok or retry status.
   a_msg_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_msg_valid) |->
         (rsp_status == STATUS_OK || rsp_status == STATUS_RETRY))
      else $error("message sent with error status");

   // The held count moves by at most one per cycle.
   a_total_step: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> (total_ff == $past(total_ff)
                || total_ff == $past(total_ff) + HELD_CNT_W'(1)
                || total_ff == $past(total_ff) - HELD_CNT_W'(1)))
      else $error("held count jumped");

   // Reset always starts a clearing pass.
   a_reset_clears: assert property (@(posedge clock)
      reset |=> busy)
      else $error("block not busy after reset");

endmodule

`default_nettype wire

@@ tb/tb.sv @@
// Self-checking testbench for the cached lock grant table, with directed and random transactions.
`timescale 1ns / 100ps

module tb;
   import clgt_pkg::*;

   localparam int LOCKS  = DEF_NUM_LOCKS;
   localparam int QDEPTH = DEF_QUEUE_DEPTH;
   localparam logic [ACTION_W-1:0] ACT_STAT     = 2'd2;
   localparam logic [ACTION_W-1:0] ACT_STAT_ALT = 2'd3;

   typedef struct packed {
      logic [STATUS_W-1:0]   status;
      logic                  msg_valid;
      logic                  msg_kind;
      logic [CLIENT_W-1:0]   msg_client;
      logic [LOCK_ID_W-1:0]  msg_lock;
      logic [HELD_CNT_W-1:0] held;
   } lock_outcome_type;

   typedef struct {
      logic [ACTION_W-1:0]  action;
      logic [LOCK_ID_W-1:0] lock_id;
      logic [CLIENT_W-1:0]  client;
      logic                 reach;
      bit                   typed;
      lock_outcome_type     outcome;
   } lock_request_type;

   logic                    clock;
   logic                    reset;
   logic                    start;
   logic                    busy;
   logic [ACTION_W-1:0]     req_action;
   logic [LOCK_ID_W-1:0]    req_lock_id;
   logic [CLIENT_W-1:0]     req_client_id;
   logic                    req_target_reachable;
   logic                    rsp_strobe;
   logic [STATUS_W-1:0]     rsp_status;
   logic                    rsp_msg_valid;
   logic                    rsp_msg_kind;
   logic [CLIENT_W-1:0]     rsp_msg_client;
   logic [LOCK_ID_W-1:0]    rsp_msg_lock;
   logic [HELD_CNT_W-1:0]   rsp_held_count;

   logic                    lock_taken [LOCKS];
   logic [CLIENT_W-1:0]     lock_holder [LOCKS];
   logic [CLIENT_W-1:0]     waiter_ring [LOCKS][QDEPTH];
   int                      ring_head [LOCKS];
   int                      ring_fill [LOCKS];
   logic [HELD_CNT_W-1:0]   locks_granted;

   lock_outcome_type        pending_outcomes [$];
   lock_request_type        directed_rows [$];
   int                      fail_count;

   cached_lock_grant_table dut (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_action           (req_action),
      .req_lock_id          (req_lock_id),
      .req_client_id        (req_client_id),
      .req_target_reachable (req_target_reachable),
      .rsp_strobe           (rsp_strobe),
      .rsp_status           (rsp_status),
      .rsp_msg_valid        (rsp_msg_valid),
      .rsp_msg_kind         (rsp_msg_kind),
      .rsp_msg_client       (rsp_msg_client),
      .rsp_msg_lock         (rsp_msg_lock),
      .rsp_held_count       (rsp_held_count)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("cached_lock_grant_table test failed");
      $finish;
   end

   function automatic lock_outcome_type predict_lock_outcome(input logic [ACTION_W-1:0] act,
                                                            input logic [LOCK_ID_W-1:0] lk,
                                                            input logic [CLIENT_W-1:0] cl,
                                                            input logic reach);
      lock_outcome_type    o;
      int                  n;
      int                  h;
      logic [CLIENT_W-1:0] target;
      o = '0;
      n = ring_fill[lk];
      h = ring_head[lk];
      if (act == ACT_ACQUIRE) begin
         if (!lock_taken[lk]) begin
            lock_taken[lk] = 1'b1;
            lock_holder[lk] = cl;
            if (locks_granted != HELD_MAX) locks_granted = locks_granted + 1'b1;
         end else if (n >= QDEPTH) begin
            o.status = STATUS_FULL;
         end else begin
            target = (n != 0) ? waiter_ring[lk][(h + n - 1) % QDEPTH] : lock_holder[lk];
            waiter_ring[lk][(h + n) % QDEPTH] = cl;
            ring_fill[lk] = n + 1;
            if (reach) begin
               o.status = STATUS_RETRY;
               o.msg_valid = 1'b1;
               o.msg_kind = MSG_REVOKE;
               o.msg_client = target;
               o.msg_lock = lk;
            end else begin
               o.status = STATUS_RPC;
            end
         end
      end else if (act == ACT_RELEASE) begin
         if (n != 0) begin
            target = waiter_ring[lk][h];
            ring_head[lk] = (h + 1) % QDEPTH;
            ring_fill[lk] = n - 1;
            lock_holder[lk] = target;
            lock_taken[lk] = 1'b1;
            if (reach) begin
               o.msg_valid = 1'b1;
               o.msg_kind = MSG_RETRY;
               o.msg_client = target;
               o.msg_lock = lk;
            end else begin
               o.status = STATUS_RPC;
            end
         end else begin
            if (lock_taken[lk] && locks_granted != 0) locks_granted = locks_granted - 1'b1;
            lock_taken[lk] = 1'b0;
            lock_holder[lk] = '0;
         end
      end
      o.held = locks_granted;
      return o;
   endfunction

   function automatic void check_field(input string name, input logic [31:0] expected,
                                       input logic [31:0] actual);
      if (expected !== actual) begin
         $error("%s: expected %0d, got %0d", name, expected, actual);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      lock_outcome_type want;
      if (!reset && rsp_strobe) begin
         if (pending_outcomes.size() == 0) begin
            $error("response transaction with no request outstanding");
            fail_count++;
         end else begin
            want = pending_outcomes.pop_front();
            check_field("status", want.status, rsp_status);
            check_field("msg_valid", want.msg_valid, rsp_msg_valid);
            check_field("msg_kind", want.msg_kind, rsp_msg_kind);
            check_field("msg_client", want.msg_client, rsp_msg_client);
            check_field("msg_lock", want.msg_lock, rsp_msg_lock);
            check_field("held_count", want.held, rsp_held_count);
         end
      end
   end

   task automatic issue_request(input lock_request_type rq, input int gap);
      lock_outcome_type predicted;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_action <= rq.action;
      req_lock_id <= rq.lock_id;
      req_client_id <= rq.client;
      req_target_reachable <= rq.reach;
      @(posedge clock);
      while (busy) @(posedge clock);
      predicted = predict_lock_outcome(rq.action, rq.lock_id, rq.client, rq.reach);
      pending_outcomes.push_back(rq.typed ? rq.outcome : predicted);
   endtask

   task automatic drain_responses();
      start <= 1'b0;
      @(posedge clock);
      while (pending_outcomes.size() != 0) @(posedge clock);
   endtask

   function automatic lock_request_type random_request();
      lock_request_type rq;
      int               pick;
      rq.typed = 1'b0;
      rq.outcome = '0;
      if ($urandom_range(0, 99) < 75) rq.lock_id = LOCK_ID_W'($urandom_range(0, 3) * 21);
      else rq.lock_id = LOCK_ID_W'($urandom_range(0, LOCKS - 1));
      pick = $urandom_range(0, 99);
      if (pick < 50) rq.action = ACT_ACQUIRE;
      else if (pick < 85) rq.action = ACT_RELEASE;
      else rq.action = ($urandom_range(0, 1) != 0) ? ACT_STAT : ACT_STAT_ALT;
      rq.client = CLIENT_W'($urandom_range(0, 15));
      rq.reach = ($urandom_range(0, 9) != 0);
      return rq;
   endfunction

   initial begin
      lock_outcome_type none;
      bit               quiet;
      none = '0;
      fail_count = 0;
      locks_granted = '0;
      for (int i = 0; i < LOCKS; i++) begin
         lock_taken[i] = 1'b0;
         lock_holder[i] = '0;
         ring_head[i] = 0;
         ring_fill[i] = 0;
      end

      // Queue fills on lock 0, overflows, partly drains with hand-over and then wraps.
      directed_rows.push_back('{ACT_STAT, 6'd0, 4'd0, 1'b1, 1'b1,
                                '{STATUS_OK, 1'b0, 1'b0, 4'd0, 6'd0, 7'd0}});
      directed_rows.push_back('{ACT_STAT_ALT, 6'd63, 4'd15, 1'b0, 1'b1,
                                '{STATUS_OK, 1'b0, 1'b0, 4'd0, 6'd0, 7'd0}});
      directed_rows.push_back('{ACT_RELEASE, 6'd63, 4'd7, 1'b1, 1'b1,
                                '{STATUS_OK, 1'b0, 1'b0, 4'd0, 6'd0, 7'd0}});
      directed_rows.push_back('{ACT_ACQUIRE, 6'd0, 4'd15, 1'b1, 1'b1,
                                '{STATUS_OK, 1'b0, 1'b0, 4'd0, 6'd0, 7'd1}});
      directed_rows.push_back('{ACT_ACQUIRE, 6'd63, 4'd0, 1'b1, 1'b1,
                                '{STATUS_OK, 1'b0, 1'b0, 4'd0, 6'd0, 7'd2}});
      directed_rows.push_back('{ACT_ACQUIRE, 6'd0, 4'd1, 1'b1, 1'b1,
                                '{STATUS_RETRY, 1'b1, MSG_REVOKE, 4'd15, 6'd0, 7'd2}});
      directed_rows.push_back('{ACT_ACQUIRE, 6'd0, 4'd2, 1'b0, 1'b1,
                                '{STATUS_RPC, 1'b0, 1'b0, 4'd0, 6'd0, 7'd2}});
      directed_rows.push_back('{ACT_ACQUIRE, 6'd0, 4'd3, 1'b1, 1'b1,
                                '{STATUS_RETRY, 1'b1, MSG_REVOKE, 4'd2, 6'd0, 7'd2}});
      for (int c = 4; c <= 8; c++)
         directed_rows.push_back('{ACT_ACQUIRE, 6'd0, CLIENT_W'(c), 1'b1, 1'b0, none});
      directed_rows.push_back('{ACT_ACQUIRE, 6'd0, 4'd9, 1'b1, 1'b1,
                                '{STATUS_FULL, 1'b0, 1'b0, 4'd0, 6'd0, 7'd2}});
      directed_rows.push_back('{ACT_RELEASE, 6'd0, 4'd15, 1'b1, 1'b1,
                                '{STATUS_OK, 1'b1, MSG_RETRY, 4'd1, 6'd0, 7'd2}});
      directed_rows.push_back('{ACT_RELEASE, 6'd0, 4'd1, 1'b0, 1'b1,
                                '{STATUS_RPC, 1'b0, 1'b0, 4'd0, 6'd0, 7'd2}});
      directed_rows.push_back('{ACT_RELEASE, 6'd63, 4'd5, 1'b1, 1'b1,
                                '{STATUS_OK, 1'b0, 1'b0, 4'd0, 6'd0, 7'd1}});
      directed_rows.push_back('{ACT_RELEASE, 6'd63, 4'd5, 1'b1, 1'b1,
                                '{STATUS_OK, 1'b0, 1'b0, 4'd0, 6'd0, 7'd1}});
      directed_rows.push_back('{ACT_ACQUIRE, 6'd0, 4'd10, 1'b1, 1'b0, none});
      directed_rows.push_back('{ACT_ACQUIRE, 6'd0, 4'd11, 1'b1, 1'b0, none});
      directed_rows.push_back('{ACT_ACQUIRE, 6'd0, 4'd12, 1'b1, 1'b1,
                                '{STATUS_FULL, 1'b0, 1'b0, 4'd0, 6'd0, 7'd1}});
      directed_rows.push_back('{ACT_RELEASE, 6'd0, 4'd0, 1'b1, 1'b0, none});
      directed_rows.push_back('{ACT_STAT, 6'd0, 4'd0, 1'b1, 1'b1,
                                '{STATUS_OK, 1'b0, 1'b0, 4'd0, 6'd0, 7'd1}});

      reset <= 1'b1;
      start <= 1'b0;
      req_action <= ACT_STAT;
      req_lock_id <= '0;
      req_client_id <= '0;
      req_target_reachable <= 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         issue_request(directed_rows[i], ($urandom_range(0, 1) != 0) ? $urandom_range(0, 18) : 0);
      drain_responses();

      quiet = 1'b0;
      for (int n = 0; n < 1000; n++) begin
         if (n % 40 == 0) quiet = ($urandom_range(0, 2) == 0);
         if (n % 250 == 249) drain_responses();
         issue_request(random_request(), quiet ? 0 : $urandom_range(0, 18));
      end
      start <= 1'b0;

      @(posedge clock);
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("cached_lock_grant_table test passed");
      end else begin
         $display("cached_lock_grant_table test failed");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
sv/clgt_pkg.sv
sv/clgt_step_unit.sv
sv/clgt_wait_mem.sv
sv/clgt_lock_mem.sv
sv/cached_lock_grant_table.sv
tb/tb.sv
